@@ rtl/etl_pkg.sv @@
// Shared types, character codes and the escape lookup for the escaped-line
// UTF-16 to UTF-8 transcoder. No dependencies.
package etl_pkg;

	// Result slots one text unit can produce (pending backslash + 3 UTF-8 bytes)
	localparam int unsigned MaxRes = 4;
	localparam int unsigned CntW = 3;

	// Character codes
	localparam logic [15:0] ChBslash = 16'h005C;
	localparam logic [15:0] ChCr     = 16'h000D;
	localparam logic [15:0] ChLf     = 16'h000A;
	localparam logic [15:0] ChNul    = 16'h0000;
	localparam logic [15:0] MaxAscii = 16'h007F;
	localparam logic [15:0] Max2Byte = 16'h07FF;
	localparam logic [7:0]  Lead2    = 8'hC0;
	localparam logic [7:0]  Lead3    = 8'hE0;
	localparam logic [7:0]  ContByte = 8'h80;

	// Input modes
	localparam logic ModeByte  = 1'b0;
	localparam logic ModeUtf16 = 1'b1;

	// One emitted result
	typedef struct packed {
		logic [7:0] data;
		logic       line_end;
		logic       text_end;
	} res_t;

	// Everything one unit produces, in emission order from slot 0
	typedef struct packed {
		res_t [MaxRes-1:0] res;
		logic [CntW-1:0]   count;
	} dec_t;

	// Escape lookup result
	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} esc_t;

	// C-style escape letters to control bytes; backslash and both quote characters map to themselves
	function automatic esc_t esc_lookup(input logic [15:0] u);
		esc_t e;
		e.hit = 1'b1;
		unique case (u)
			16'h0061: e.data = 8'h07;
			16'h0062: e.data = 8'h08;
			16'h0066: e.data = 8'h0C;
			16'h006E: e.data = 8'h0A;
			16'h0072: e.data = 8'h0D;
			16'h0074: e.data = 8'h09;
			16'h0076: e.data = 8'h0B;
			16'h005C: e.data = 8'h5C;
			16'h0027: e.data = 8'h27;
			16'h0022: e.data = 8'h22;
			default: begin
				e.hit = 1'b0;
				e.data = 8'h00;
			end
		endcase
		return e;
	endfunction

endpackage

@@ rtl/escaped_line_utf16_to_utf8.sv @@
// Escaped-line UTF-16 to UTF-8 transcoder, top level.
// An input transfer passes the input register, then the result buffer, before its
// first result is shown. Throughput: one unit per cycle when each unit yields at
// most one result and m_tready is held high; a unit yielding several results
// holds the input until the single output port has drained them from the result
// buffer. Units yielding no result do not hold the input. Reset (arst_n low) clears
// escape/CR state, empties both stages and sets input_mode to 1 (UTF-16).
// Depends on etl_pkg, etl_decode, etl_emit.
module escaped_line_utf16_to_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,   // input_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] code_unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [7:0] out_byte
	output logic [1:0]  m_tuser,     // [0] line_end, [1] text_end
	output logic        m_tlast
);

	logic          mode_q;
	logic          vld_s1;
	logic [15:0]   unit_s1;
	logic          can_load;
	logic          advance;
	etl_pkg::dec_t dec;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= etl_pkg::ModeUtf16;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// Input stage moves on when the result buffer can take its results
	assign advance  = vld_s1 && can_load;
	assign s_tready = !vld_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			unit_s1 <= s_tdata;
		end
	end

	etl_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.unit    (unit_s1),
		.advance (advance),
		.dec     (dec)
	);

	etl_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.dec      (dec),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/etl_decode.sv @@
// Unit decoder: escape, line-end and UTF-8 expansion of one text unit,
// plus the escape and CR state. Depends on etl_pkg.
module etl_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode,
	input  logic [15:0]    unit,
	input  logic           advance,
	output etl_pkg::dec_t  dec
);

	logic esc_pend_q;
	logic after_cr_q;
	logic esc_pend_nxt;
	logic after_cr_nxt;

	// Expand one unit into its results
	always_comb begin
		logic [15:0]              u;
		logic                     prev_cr;
		logic                     done;
		logic [etl_pkg::CntW-1:0] n;
		etl_pkg::esc_t            e;
		etl_pkg::res_t [etl_pkg::MaxRes-1:0] r;

		u = (mode == etl_pkg::ModeUtf16) ? unit : {8'h00, unit[7:0]};
		prev_cr = after_cr_q;
		done = 1'b0;
		n = '0;
		r = '0;
		e = etl_pkg::esc_lookup(u);
		esc_pend_nxt = 1'b0;
		after_cr_nxt = 1'b0;

		// Backslash waiting: known escape collapses, else a literal backslash
		if (esc_pend_q) begin
			prev_cr = 1'b0;
			if (e.hit) begin
				r[0] = '{data: e.data, line_end: 1'b0, text_end: 1'b0};
				done = 1'b1;
			end else begin
				r[0] = '{data: etl_pkg::ChBslash[7:0], line_end: 1'b0, text_end: 1'b0};
			end
			n = 3'd1;
		end

		if (!done) begin
			if (u == etl_pkg::ChBslash) begin
				esc_pend_nxt = 1'b1;
			end else if (u == etl_pkg::ChCr) begin
				r[n[1:0]] = '{data: 8'h00, line_end: 1'b1, text_end: 1'b0};
				n = n + 3'd1;
				after_cr_nxt = 1'b1;
			end else if (u == etl_pkg::ChLf) begin
				if (!prev_cr) begin
					r[n[1:0]] = '{data: 8'h00, line_end: 1'b1, text_end: 1'b0};
					n = n + 3'd1;
				end
			end else if (u == etl_pkg::ChNul) begin
				r[n[1:0]] = '{data: 8'h00, line_end: 1'b0, text_end: 1'b1};
				n = n + 3'd1;
			end else if (mode == etl_pkg::ModeByte || u <= etl_pkg::MaxAscii) begin
				r[n[1:0]] = '{data: u[7:0], line_end: 1'b0, text_end: 1'b0};
				n = n + 3'd1;
			end else if (u <= etl_pkg::Max2Byte) begin
				r[n[1:0]] = '{data: etl_pkg::Lead2 | {3'b000, u[10:6]},
					line_end: 1'b0, text_end: 1'b0};
				r[n[1:0] + 2'd1] = '{data: etl_pkg::ContByte | {2'b00, u[5:0]},
					line_end: 1'b0, text_end: 1'b0};
				n = n + 3'd2;
			end else begin
				r[n[1:0]] = '{data: etl_pkg::Lead3 | {4'b0000, u[15:12]},
					line_end: 1'b0, text_end: 1'b0};
				r[n[1:0] + 2'd1] = '{data: etl_pkg::ContByte | {2'b00, u[11:6]},
					line_end: 1'b0, text_end: 1'b0};
				r[n[1:0] + 2'd2] = '{data: etl_pkg::ContByte | {2'b00, u[5:0]},
					line_end: 1'b0, text_end: 1'b0};
				n = n + 3'd3;
			end
		end

		dec.res = r;
		dec.count = n;
	end

	// Escape / CR state, updated as the unit is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			after_cr_q <= 1'b0;
		end else if (advance) begin
			esc_pend_q <= esc_pend_nxt;
			after_cr_q <= after_cr_nxt;
		end
	end

endmodule

@@ rtl/etl_emit.sv @@
// Result buffer: holds the results of one unit and sends them one per
// transfer on the master stream. Depends on etl_pkg.
module etl_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  etl_pkg::dec_t  dec,
	output logic           can_load,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // [7:0] out_byte
	output logic [1:0]     m_tuser,   // [0] line_end, [1] text_end
	output logic           m_tlast
);

	etl_pkg::res_t [etl_pkg::MaxRes-1:0] res_q;
	logic [etl_pkg::CntW-1:0] cnt_q;
	logic [1:0]               idx_q;
	logic                     is_last;
	logic                     take;

	assign m_tvalid = (cnt_q != '0);
	assign is_last  = ({1'b0, idx_q} == (cnt_q - 3'd1));
	assign take     = m_tvalid && m_tready;
	// Buffer can refill when empty or as its final result leaves
	assign can_load = !m_tvalid || (take && is_last);

	assign m_tdata  = res_q[idx_q].data;
	assign m_tuser  = {res_q[idx_q].text_end, res_q[idx_q].line_end};
	assign m_tlast  = is_last;

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= dec.res;
		end
	end

	// Fill count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= dec.count;
			idx_q <= '0;
		end else if (take) begin
			if (is_last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
